/* hw/rtl/gda_pkg.sv */
package gda_pkg;

    // Default sizes of the table and of the counters.
    localparam int DEF_INDIVIDUALS = 256;
    localparam int DEF_MARKERS     = 1024;
    localparam int DEF_COUNT_WIDTH = 15;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Fixed field widths of the request and the result.
    localparam int KIND_W   = 2;
    localparam int IND_W    = 8;
    localparam int MARK_W   = 10;
    localparam int DOSE_W   = 16;
    localparam int QUAL_W   = 17;
    localparam int BEST_W   = 2;

    // Fixed-point formats of the two quotients.
    localparam int DOSE_FRAC = 14;
    localparam int QUAL_FRAC = 16;
    localparam logic [DOSE_W-1:0] DOSE_MAX = 16'd32768;
    localparam logic [QUAL_W-1:0] QUAL_ONE = 17'd65536;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FINISH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_STORE_DOSAGE       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STORE_DISTRIBUTION = 1'd1;

    // Genotype classes.
    localparam logic [BEST_W-1:0] GENO_ZERO = 2'd0;
    localparam logic [BEST_W-1:0] GENO_ONE  = 2'd1;
    localparam logic [BEST_W-1:0] GENO_TWO  = 2'd2;

    // Operations queued from the front to the back.
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic       op;
        logic [1:0] sum_inc;
        logic       two_inc;
        logic       blank;
    } t_cmd;

endpackage

/* hw/rtl/gda_req_if.sv */
interface gda_req_if;
    logic                          valid;
    logic                          ready;
    logic [gda_pkg::KIND_W-1:0]    kind;
    logic [gda_pkg::IND_W-1:0]     individual;
    logic [gda_pkg::MARK_W-1:0]    marker;
    logic                          allele_a;
    logic                          allele_b;

    modport source (
        output valid, kind, individual, marker, allele_a, allele_b,
        input  ready
    );
    modport sink (
        input  valid, kind, individual, marker, allele_a, allele_b,
        output ready
    );
endinterface

/* hw/rtl/gda_rsp_if.sv */
interface gda_rsp_if #(
    parameter int COUNT_WIDTH = gda_pkg::DEF_COUNT_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic [COUNT_WIDTH-1:0]        count_zero;
    logic [COUNT_WIDTH-1:0]        count_one;
    logic [COUNT_WIDTH-1:0]        count_two;
    logic [gda_pkg::DOSE_W-1:0]    dosage_fixed;
    logic [gda_pkg::QUAL_W-1:0]    quality_fixed;
    logic [gda_pkg::BEST_W-1:0]    best_genotype;

    modport source (
        output valid, count_zero, count_one, count_two, dosage_fixed,
               quality_fixed, best_genotype,
        input  ready
    );
    modport sink (
        input  valid, count_zero, count_one, count_two, dosage_fixed,
               quality_fixed, best_genotype,
        output ready
    );
endinterface

/* hw/rtl/gda_ram.sv */
module gda_ram #(
    parameter int              WIDTH = 8,
    parameter longint unsigned DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-first: a read and a write to one address in the same cycle
    // returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/gda_fifo.sv */
module gda_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push_ok, pop_ok;

    assign o_valid = (r_count != '0);
    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (pop_ok) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* hw/rtl/gda_front.sv */
module gda_front #(
    parameter int INDIVIDUALS = gda_pkg::DEF_INDIVIDUALS,
    parameter int MARKERS     = gda_pkg::DEF_MARKERS,
    parameter int COUNT_WIDTH = gda_pkg::DEF_COUNT_WIDTH,
    parameter int ADDR_W      = 18
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    gda_req_if.sink                i_req,
    input  logic                   i_store_dosage,
    input  logic                   i_store_distribution,
    input  logic                   i_clearing,
    input  logic                   i_q_ready,
    output logic                   o_push,
    output gda_pkg::t_cmd          o_cmd,
    output logic [ADDR_W-1:0]      o_addr,
    output logic [COUNT_WIDTH-1:0] o_rounds
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] r_rounds, n_rounds;
    logic                   accept;
    logic                   dosage_on;
    logic                   in_table;
    logic [ADDR_W-1:0]      row;

    assign i_req.ready = i_q_ready && !i_clearing;
    assign accept      = i_req.valid && i_req.ready;
    assign dosage_on   = i_store_dosage || i_store_distribution;
    assign in_table    = (32'(i_req.individual) < 32'(INDIVIDUALS)) &&
                         (32'(i_req.marker) < 32'(MARKERS));
    assign row         = ADDR_W'(64'(i_req.individual) * 64'(MARKERS) +
                                 64'(i_req.marker));

    // Queries carry the round count as it stands when they arrive.
    assign o_rounds = r_rounds;
    assign o_addr   = in_table ? row : '0;

    always_comb begin
        o_push   = 1'b0;
        o_cmd    = '0;
        n_rounds = r_rounds;
        if (accept) begin
            case (i_req.kind)
                gda_pkg::KIND_ADD: begin
                    o_push        = dosage_on && in_table;
                    o_cmd.op      = gda_pkg::OP_ADD;
                    o_cmd.sum_inc = {1'b0, i_req.allele_a} + {1'b0, i_req.allele_b};
                    o_cmd.two_inc = i_store_distribution && i_req.allele_a &&
                                    i_req.allele_b;
                end
                gda_pkg::KIND_FINISH: begin
                    if (dosage_on && r_rounds != COUNT_MAX) begin
                        n_rounds = r_rounds + 1'b1;
                    end
                end
                gda_pkg::KIND_QUERY: begin
                    o_push      = 1'b1;
                    o_cmd.op    = gda_pkg::OP_QUERY;
                    o_cmd.blank = !in_table;
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rounds <= '0;
        end else begin
            r_rounds <= n_rounds;
        end
    end

endmodule

/* hw/rtl/gda_back.sv */
module gda_back #(
    parameter int              COUNT_WIDTH = gda_pkg::DEF_COUNT_WIDTH,
    parameter longint unsigned ENTRIES     = 262144,
    parameter int              ADDR_W      = 18
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_head_valid,
    input  gda_pkg::t_cmd          i_head_cmd,
    input  logic [ADDR_W-1:0]      i_head_addr,
    input  logic [COUNT_WIDTH-1:0] i_head_rounds,
    output logic                   o_pop,
    output logic                   o_qry_valid,
    input  logic                   i_qry_ready,
    output logic [COUNT_WIDTH:0]   o_qry_sum,
    output logic [COUNT_WIDTH-1:0] o_qry_two,
    output logic [COUNT_WIDTH-1:0] o_qry_rounds,
    output logic                   o_clearing
);

    localparam int SW = COUNT_WIDTH + 1;
    localparam int EW = SW + COUNT_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [SW-1:0]          SUM_MAX   = {{COUNT_WIDTH{1'b1}}, 1'b0};
    localparam logic [ADDR_W-1:0]      LAST_ADDR = ADDR_W'(ENTRIES - 1);

    logic                   r_clearing;
    logic [ADDR_W-1:0]      r_clr_addr;

    logic                   r_b_valid;
    gda_pkg::t_cmd          r_b_cmd;
    logic [ADDR_W-1:0]      r_b_addr;
    logic [COUNT_WIDTH-1:0] r_b_rounds;

    logic                   r_fwd_valid;
    logic [ADDR_W-1:0]      r_fwd_addr;
    logic [EW-1:0]          r_fwd_data;

    logic [EW-1:0]          rd_data, cur_entry, new_entry, wr_data;
    logic [ADDR_W-1:0]      wr_addr;
    logic                   we, upd;
    logic [SW-1:0]          cur_sum, new_sum;
    logic [SW:0]            sum_ext;
    logic [COUNT_WIDTH-1:0] cur_two, new_two;
    logic                   b_is_query, b_fire, b_free;

    // The entry read when the item was popped may already be stale if the previous item
    // wrote the same address; the last write is kept and bypassed.
    assign cur_entry = (r_fwd_valid && r_fwd_addr == r_b_addr) ? r_fwd_data : rd_data;
    assign cur_sum   = cur_entry[EW-1:COUNT_WIDTH];
    assign cur_two   = cur_entry[COUNT_WIDTH-1:0];

    assign sum_ext   = {1'b0, cur_sum} + (SW + 1)'(r_b_cmd.sum_inc);
    assign new_sum   = (sum_ext > {1'b0, SUM_MAX}) ? SUM_MAX : sum_ext[SW-1:0];
    assign new_two   = (r_b_cmd.two_inc && cur_two != COUNT_MAX) ?
                       cur_two + 1'b1 : cur_two;
    assign new_entry = {new_sum, new_two};

    assign b_is_query = (r_b_cmd.op == gda_pkg::OP_QUERY);
    assign b_fire     = r_b_valid && (!b_is_query || i_qry_ready);
    assign b_free     = !r_b_valid || b_fire;
    assign o_pop      = i_head_valid && b_free && !r_clearing;
    assign upd        = b_fire && !b_is_query;

    assign we      = r_clearing || upd;
    assign wr_addr = r_clearing ? r_clr_addr : r_b_addr;
    assign wr_data = r_clearing ? '0 : new_entry;

    assign o_qry_valid  = r_b_valid && b_is_query;
    assign o_qry_sum    = r_b_cmd.blank ? '0 : cur_sum;
    assign o_qry_two    = r_b_cmd.blank ? '0 : cur_two;
    assign o_qry_rounds = r_b_rounds;
    assign o_clearing   = r_clearing;

    gda_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (o_pop),
        .i_raddr (i_head_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_b_valid   <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                if (r_clr_addr == LAST_ADDR) begin
                    r_clearing <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
            end
            if (b_free) begin
                r_b_valid <= o_pop;
            end
            if (upd) begin
                r_fwd_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_cmd    <= i_head_cmd;
            r_b_addr   <= i_head_addr;
            r_b_rounds <= i_head_rounds;
        end
        if (upd) begin
            r_fwd_addr <= r_b_addr;
            r_fwd_data <= new_entry;
        end
    end

endmodule

/* hw/rtl/gda_query.sv */
module gda_query #(
    parameter int COUNT_WIDTH = gda_pkg::DEF_COUNT_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [COUNT_WIDTH:0]   i_sum,
    input  logic [COUNT_WIDTH-1:0] i_two,
    input  logic [COUNT_WIDTH-1:0] i_rounds,
    gda_rsp_if.source              o_rsp
);

    localparam int CW     = COUNT_WIDTH;
    localparam int SW     = CW + 1;
    localparam int W      = CW + 17;
    localparam int STEP_W = $clog2(W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(W - 1);
    localparam logic [CW-1:0]     COUNT_MAX = {CW{1'b1}};

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CNT  = 3'd1;
    localparam logic [2:0] S_SEL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_HOLD = 3'd4;

    logic [2:0]                   r_state;
    logic [SW-1:0]                r_sum;
    logic [CW-1:0]                r_two, r_rnd;
    logic [CW-1:0]                r_n0, r_n1, r_n2, r_top;
    logic [gda_pkg::BEST_W-1:0]   r_best;
    logic [gda_pkg::DOSE_W-1:0]   r_dose;
    logic [gda_pkg::QUAL_W-1:0]   r_qual;
    logic [CW-1:0]                r_rem;
    logic [W-1:0]                 r_quo;
    logic [STEP_W-1:0]            r_step;
    logic                         r_pass;

    logic [SW-1:0]                twice_n2, n1_full, n21, twice_r, dnum;
    logic [CW-1:0]                n1_c, n0_c, top_c;
    logic [gda_pkg::BEST_W-1:0]   best_c;
    logic [W-1:0]                 half_r, dose_num, qual_num, quo_next;
    logic [SW-1:0]                trial;
    logic                         ge;
    logic [CW-1:0]                rem_next;

    // Class counts recovered from the allele sum and the double count.
    assign twice_n2 = {r_two, 1'b0};
    assign n1_full  = (r_sum >= twice_n2) ? r_sum - twice_n2 : '0;
    assign n1_c     = n1_full[SW-1] ? COUNT_MAX : n1_full[CW-1:0];
    assign n21      = {1'b0, r_n2} + {1'b0, r_n1};
    assign n0_c     = ({1'b0, r_rnd} >= n21) ? CW'({1'b0, r_rnd} - n21) : '0;

    always_comb begin
        if (n0_c >= r_n2 && n0_c >= r_n1) begin
            best_c = gda_pkg::GENO_ZERO;
            top_c  = n0_c;
        end else if (r_n1 >= r_n2) begin
            best_c = gda_pkg::GENO_ONE;
            top_c  = r_n1;
        end else begin
            best_c = gda_pkg::GENO_TWO;
            top_c  = r_n2;
        end
    end

    // Rounded quotients: half the divisor is added to the dividend.
    assign twice_r  = {r_rnd, 1'b0};
    assign dnum     = (twice_r >= r_sum) ? twice_r - r_sum : '0;
    assign half_r   = W'(r_rnd >> 1);
    assign dose_num = W'({dnum, {gda_pkg::DOSE_FRAC{1'b0}}}) + half_r;
    assign qual_num = W'({r_top, {gda_pkg::QUAL_FRAC{1'b0}}}) + half_r;

    // One restoring division step per cycle.
    assign trial    = {r_rem, r_quo[W-1]};
    assign ge       = (trial >= {1'b0, r_rnd});
    assign rem_next = ge ? CW'(trial - {1'b0, r_rnd}) : trial[CW-1:0];
    assign quo_next = {r_quo[W-2:0], ge};

    assign o_ready             = (r_state == S_IDLE);
    assign o_rsp.valid         = (r_state == S_HOLD);
    assign o_rsp.count_zero    = r_n0;
    assign o_rsp.count_one     = r_n1;
    assign o_rsp.count_two     = r_n2;
    assign o_rsp.dosage_fixed  = r_dose;
    assign o_rsp.quality_fixed = r_qual;
    assign o_rsp.best_genotype = r_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_CNT;
                    end
                end
                S_CNT: begin
                    r_state <= S_SEL;
                end
                S_SEL: begin
                    r_state <= (r_rnd == '0) ? S_HOLD : S_DIV;
                end
                S_DIV: begin
                    if (r_step == STEP_LAST && r_pass) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (o_rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_sum <= i_sum;
                r_two <= i_two;
                r_rnd <= i_rounds;
            end
            S_CNT: begin
                r_n1 <= n1_c;
                r_n2 <= r_two;
            end
            S_SEL: begin
                if (r_rnd == '0) begin
                    r_n0   <= '0;
                    r_n1   <= '0;
                    r_n2   <= '0;
                    r_best <= gda_pkg::GENO_ONE;
                    r_dose <= '0;
                    r_qual <= '0;
                end else begin
                    r_n0   <= n0_c;
                    r_best <= best_c;
                    r_top  <= top_c;
                    r_quo  <= dose_num;
                    r_rem  <= '0;
                    r_step <= '0;
                    r_pass <= 1'b0;
                end
            end
            S_DIV: begin
                if (r_step == STEP_LAST) begin
                    if (!r_pass) begin
                        r_dose <= quo_next[gda_pkg::DOSE_W-1:0];
                        r_quo  <= qual_num;
                        r_rem  <= '0;
                        r_step <= '0;
                        r_pass <= 1'b1;
                    end else begin
                        r_qual <= (quo_next > W'(gda_pkg::QUAL_ONE)) ?
                                  gda_pkg::QUAL_ONE : quo_next[gda_pkg::QUAL_W-1:0];
                    end
                end else begin
                    r_quo  <= quo_next;
                    r_rem  <= rem_next;
                    r_step <= r_step + 1'b1;
                end
            end
            default: begin
                r_sum <= r_sum;
            end
        endcase
    end

endmodule

/* hw/rtl/genotype_dosage_accumulator.sv */
// An add passes through the queue and then the back's stage register before it is written
// to the table; a query result comes from the bit-serial divider in the query unit.
// Throughput: one add or finish per cycle (one read-modify-write per cycle on the table)
// while the queue has room and no clearing pass runs; the query unit takes a new query only
// once its last result has been taken. Reset: synchronous, active low; a clearing pass zeroes
// all INDIVIDUALS*MARKERS entries of the table (262144 by default), requests wait.
module genotype_dosage_accumulator #(
    parameter int INDIVIDUALS = gda_pkg::DEF_INDIVIDUALS,
    parameter int MARKERS     = gda_pkg::DEF_MARKERS,
    parameter int COUNT_WIDTH = gda_pkg::DEF_COUNT_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gda_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gda_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    gda_req_if.sink                           i_req,
    gda_rsp_if.source                         o_rsp
);

    // The table holds one entry per individual and marker. Each entry packs
    // the saturating allele sum above the saturating double count.
    localparam longint unsigned ENTRIES = 64'(INDIVIDUALS) * 64'(MARKERS);
    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CMD_W  = $bits(gda_pkg::t_cmd);
    localparam int Q_W    = CMD_W + ADDR_W + COUNT_WIDTH;

    // Configuration registers. Storing distributions implies storing dosages.
    logic r_store_dosage;
    logic r_store_distribution;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store_dosage       <= 1'b0;
            r_store_distribution <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gda_pkg::CFG_STORE_DOSAGE:       r_store_dosage       <= i_cfg_data[0];
                gda_pkg::CFG_STORE_DISTRIBUTION: r_store_distribution <= i_cfg_data[0];
                default: begin
                    r_store_dosage <= r_store_dosage;
                end
            endcase
        end
    end

    // The front classifies each request: finishes bump the round counter on the
    // spot while storage is on, adds that cannot change the table and unused kinds
    // are dropped, the rest go into a short queue with their table address and, for
    // queries, the round count in force when the query arrived.
    logic                   clearing;
    logic                   push;
    gda_pkg::t_cmd          push_cmd;
    logic [ADDR_W-1:0]      push_addr;
    logic [COUNT_WIDTH-1:0] push_rounds;
    logic                   q_ready, q_valid, q_pop;
    logic [Q_W-1:0]         q_out;
    gda_pkg::t_cmd          head_cmd;
    logic [ADDR_W-1:0]      head_addr;
    logic [COUNT_WIDTH-1:0] head_rounds;

    gda_front #(
        .INDIVIDUALS (INDIVIDUALS),
        .MARKERS     (MARKERS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .ADDR_W      (ADDR_W)
    ) u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_req                (i_req),
        .i_store_dosage       (r_store_dosage),
        .i_store_distribution (r_store_distribution),
        .i_clearing           (clearing),
        .i_q_ready            (q_ready),
        .o_push               (push),
        .o_cmd                (push_cmd),
        .o_addr               (push_addr),
        .o_rounds             (push_rounds)
    );

    gda_fifo #(
        .WIDTH (Q_W),
        .DEPTH (gda_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_cmd, push_addr, push_rounds}),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    assign head_cmd    = q_out[Q_W-1 -: CMD_W];
    assign head_addr   = q_out[COUNT_WIDTH +: ADDR_W];
    assign head_rounds = q_out[COUNT_WIDTH-1:0];

    // The back reads the entry, then writes the update from its stage register
    // with a bypass of the previous write, so back-to-back adds to the same entry
    // see each other. Queries leave the back with the entry they read.
    logic                   qry_valid, qry_ready;
    logic [COUNT_WIDTH:0]   qry_sum;
    logic [COUNT_WIDTH-1:0] qry_two, qry_rounds;

    gda_back #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .ENTRIES     (ENTRIES),
        .ADDR_W      (ADDR_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (q_valid),
        .i_head_cmd    (head_cmd),
        .i_head_addr   (head_addr),
        .i_head_rounds (head_rounds),
        .o_pop         (q_pop),
        .o_qry_valid   (qry_valid),
        .i_qry_ready   (qry_ready),
        .o_qry_sum     (qry_sum),
        .o_qry_two     (qry_two),
        .o_qry_rounds  (qry_rounds),
        .o_clearing    (clearing)
    );

    // The query unit derives the class counts and the best class and, if a round has
    // finished, runs the dosage and quality quotients through one divider in turn. Its
    // result register holds the answer; adds flow on until the next query reaches the back.
    gda_query #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_query (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (qry_valid),
        .o_ready  (qry_ready),
        .i_sum    (qry_sum),
        .i_two    (qry_two),
        .i_rounds (qry_rounds),
        .o_rsp    (o_rsp)
    );

    // A reset always starts a clearing pass.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> clearing)
        else $error("clearing pass did not start after reset");

    // No request may slip in while the table is being cleared.
    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !(i_req.valid && i_req.ready))
        else $error("request accepted during clearing pass");

    // Quotients stay within their fixed-point ranges.
    a_quotient_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.dosage_fixed <= gda_pkg::DOSE_MAX &&
                         o_rsp.quality_fixed <= gda_pkg::QUAL_ONE))
        else $error("dosage or quality out of range");

    // When class zero is reported best, it really holds the largest count.
    a_best_is_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.best_genotype == gda_pkg::GENO_ZERO) |->
        (o_rsp.count_zero >= o_rsp.count_one && o_rsp.count_zero >= o_rsp.count_two))
        else $error("best genotype is not the largest class");

endmodule

/* dv/genotype_dosage_accumulator_test.sv */
module genotype_dosage_accumulator_test;
    import gda_pkg::*;

    // Sizes follow the defaults of the block under test.
    localparam int CW = DEF_COUNT_WIDTH;
    localparam int MARKERS_PER_INDIVIDUAL = DEF_MARKERS;
    localparam longint unsigned COUNT_MAX = (64'd1 << CW) - 1;
    localparam longint unsigned SUM_MAX = 2 * COUNT_MAX;

    // After reset the block sweeps the whole table before it takes any request, so
    // the watchdog has to tolerate that sweep with plenty of margin.
    localparam int CLEAR_CYCLES = DEF_INDIVIDUALS * DEF_MARKERS;
    localparam int WATCHDOG_LIMIT = 3 * CLEAR_CYCLES;

    // A query goes through a bit-serial divider; adds still in flight after the last result
    // pass only the queue and the back, so one query latency plus margin is a safe pause.
    localparam int QUERY_LATENCY = 2 * (CW + 17) + 4;
    localparam int SETTLE_CYCLES = QUERY_LATENCY + 16;

    localparam int LONG_HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 260;
    localparam int RANDOM_PHASES = 4;
    localparam int POOL_SIZE = 8;
    // Many more adds than rounds on one entry.
    localparam int OVERLOAD_RUN = 40;
    // Finishes sent in the closing part.
    localparam int CLOSING_ROUNDS = 24;

    // The fourth request kind has no meaning and must be dropped by the block.
    localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IND_W-1:0]  individual;
        logic [MARK_W-1:0] marker;
        logic              allele_a;
        logic              allele_b;
    } request_t;

    typedef struct packed {
        logic [CW-1:0]     count_zero;
        logic [CW-1:0]     count_one;
        logic [CW-1:0]     count_two;
        logic [DOSE_W-1:0] dosage_fixed;
        logic [QUAL_W-1:0] quality_fixed;
        logic [BEST_W-1:0] best_genotype;
    } genotype_report_t;

    // One row of the directed table: either a register write or a request that is
    // repeated a number of times, optionally with a hand-written expected report.
    typedef struct {
        bit                   is_setting;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        request_t             rq;
        int                   reps;
        bit                   pinned;
        genotype_report_t     want;
    } plan_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gda_req_if req_ch();
    gda_rsp_if #(.COUNT_WIDTH(CW)) rsp_ch();

    genotype_dosage_accumulator #(
        .INDIVIDUALS (DEF_INDIVIDUALS),
        .MARKERS     (DEF_MARKERS),
        .COUNT_WIDTH (CW)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    always #2 i_clk = ~i_clk;

    // Mirror of the block's state. Entries never touched read as zero, which matches
    // the cleared table after reset.
    int unsigned allele_sums [int unsigned];
    int unsigned both_one_counts [int unsigned];
    longint unsigned rounds_done = 0;
    bit cfg_dosage = 1'b0;
    bit cfg_distribution = 1'b0;

    genotype_report_t reports_due [$];
    plan_row_t directed_plan [$];
    request_t pool [POOL_SIZE];
    logic [1:0] pool_bias [POOL_SIZE];

    int mismatches = 0;
    int stalled_cycles = 0;
    int accepted_items = 0;
    bit idling_on = 1'b1;
    bit sink_hold_request = 1'b0;
    int src_left = 0;
    int src_rate = 0;

    function automatic longint unsigned saturate_count(input longint unsigned v);
        return (v > COUNT_MAX) ? COUNT_MAX : v;
    endfunction

    // Applies one accepted request to the mirrored table. Returns 1 when the request
    // produces a report, which is then placed in rep.
    function automatic bit apply_request(input request_t rq, output genotype_report_t rep);
        int unsigned row;
        longint unsigned allele_total, two, n0, n1, n2, top, dose, qual;
        logic [BEST_W-1:0] best;
        bit dosage_on;
        row = int'(rq.individual) * MARKERS_PER_INDIVIDUAL + int'(rq.marker);
        dosage_on = cfg_dosage || cfg_distribution;
        rep = '0;
        allele_total = allele_sums.exists(row) ? allele_sums[row] : 0;
        two = both_one_counts.exists(row) ? both_one_counts[row] : 0;
        case (rq.kind)
            KIND_ADD: begin
                if (dosage_on) begin
                    allele_total = allele_total + rq.allele_a + rq.allele_b;
                    allele_sums[row] = 32'((allele_total > SUM_MAX) ? SUM_MAX : allele_total);
                    if (cfg_distribution && rq.allele_a && rq.allele_b && two < COUNT_MAX)
                        both_one_counts[row] = 32'(two + 1);
                end
                return 1'b0;
            end
            KIND_FINISH: begin
                if (dosage_on && rounds_done < COUNT_MAX)
                    rounds_done++;
                return 1'b0;
            end
            KIND_QUERY: begin
                best = GENO_ONE;
                n0 = 0;
                n1 = 0;
                n2 = 0;
                top = 0;
                dose = 0;
                qual = 0;
                // With no finished round everything reads as zero and the
                // heterozygous class is reported as best.
                if (rounds_done != 0) begin
                    // Counters may disagree when adds come without finishes or the
                    // settings changed midway, hence the clamps on both sides.
                    n2 = saturate_count(two);
                    n1 = (allele_total >= 2 * n2) ? saturate_count(allele_total - 2 * n2) : 0;
                    n0 = (rounds_done >= n2 + n1) ? saturate_count(rounds_done - n2 - n1) : 0;
                    // Ties go to the lower class.
                    if (n0 >= n2 && n0 >= n1) begin
                        best = GENO_ZERO;
                        top = n0;
                    end else if (n1 >= n2) begin
                        best = GENO_ONE;
                        top = n1;
                    end else begin
                        best = GENO_TWO;
                        top = n2;
                    end
                    if (2 * rounds_done >= allele_total)
                        dose = (((2 * rounds_done - allele_total) << DOSE_FRAC)
                                + rounds_done / 2) / rounds_done;
                    qual = ((top << QUAL_FRAC) + rounds_done / 2) / rounds_done;
                    if (qual > QUAL_ONE)
                        qual = QUAL_ONE;
                end
                rep.count_zero    = n0[CW-1:0];
                rep.count_one     = n1[CW-1:0];
                rep.count_two     = n2[CW-1:0];
                rep.dosage_fixed  = dose[DOSE_W-1:0];
                rep.quality_fixed = qual[QUAL_W-1:0];
                rep.best_genotype = best;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic request_t make_request(input logic [KIND_W-1:0] kind,
                                              input logic [IND_W-1:0] individual,
                                              input logic [MARK_W-1:0] marker,
                                              input logic allele_a, input logic allele_b);
        request_t rq;
        rq.kind = kind;
        rq.individual = individual;
        rq.marker = marker;
        rq.allele_a = allele_a;
        rq.allele_b = allele_b;
        return rq;
    endfunction

    function automatic request_t random_request(input logic [KIND_W-1:0] kind);
        return make_request(kind, IND_W'($urandom_range(0, 255)),
                            MARK_W'($urandom_range(0, 1023)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    function automatic genotype_report_t report_of(input int n0, input int n1, input int n2,
                                                   input logic [DOSE_W-1:0] dose,
                                                   input logic [QUAL_W-1:0] qual,
                                                   input logic [BEST_W-1:0] best);
        genotype_report_t rep;
        rep.count_zero = CW'(n0);
        rep.count_one = CW'(n1);
        rep.count_two = CW'(n2);
        rep.dosage_fixed = dose;
        rep.quality_fixed = qual;
        rep.best_genotype = best;
        return rep;
    endfunction

    function automatic void plan_request(input request_t rq, input int reps = 1,
                                         input bit pinned = 1'b0,
                                         input genotype_report_t want = '0);
        plan_row_t row;
        row.is_setting = 1'b0;
        row.reg_index = '0;
        row.reg_value = '0;
        row.rq = rq;
        row.reps = reps;
        row.pinned = pinned;
        row.want = want;
        directed_plan.push_back(row);
    endfunction

    function automatic void plan_setting(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
        plan_row_t row;
        row.is_setting = 1'b1;
        row.reg_index = idx;
        row.reg_value = val;
        row.rq = '0;
        row.reps = 0;
        row.pinned = 1'b0;
        row.want = '0;
        directed_plan.push_back(row);
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Offers one request, holding it until the block takes it, and then records any
    // report that it must produce. Gaps before the request come in random bursts,
    // with calm stretches in between.
    task automatic offer_request(input request_t rq, input bit pinned,
                                 input genotype_report_t want);
        genotype_report_t predicted;
        int gap;
        gap = 0;
        if (idling_on) begin
            if (src_left == 0) begin
                src_left = $urandom_range(40, 200);
                src_rate = $urandom_range(0, 2);
            end
            src_left--;
            if (src_rate != 0 && $urandom_range(0, 15) < 2 * src_rate)
                gap = $urandom_range(1, 14);
        end
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= rq.kind;
        req_ch.individual <= rq.individual;
        req_ch.marker     <= rq.marker;
        req_ch.allele_a   <= rq.allele_a;
        req_ch.allele_b   <= rq.allele_b;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        // Requests the block simply drops do not count toward a phase.
        if (rq.kind == KIND_QUERY ||
            (rq.kind != KIND_IGNORED && (cfg_dosage || cfg_distribution)))
            accepted_items++;
        if (apply_request(rq, predicted))
            reports_due.push_back(pinned ? want : predicted);
    endtask

    // Stops offering and waits for every outstanding report. The task always waits for a
    // clock edge, so the valid that is lowered here is never raised in the same step.
    task automatic wait_reports_drained();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (reports_due.size() != 0);
    endtask

    // Register writes happen only while the block is idle: all reports are in and the
    // adds that produce no report have had time to land in the table.
    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
        wait_reports_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_STORE_DOSAGE:       cfg_dosage = val[0];
            CFG_STORE_DISTRIBUTION: cfg_distribution = val[0];
            default: ;
        endcase
    endtask

    // Report checker: every report taken from the block is compared with the oldest
    // outstanding one, field by field.
    always @(posedge i_clk) begin : check_reports
        genotype_report_t got;
        genotype_report_t want;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.count_zero    = rsp_ch.count_zero;
            got.count_one     = rsp_ch.count_one;
            got.count_two     = rsp_ch.count_two;
            got.dosage_fixed  = rsp_ch.dosage_fixed;
            got.quality_fixed = rsp_ch.quality_fixed;
            got.best_genotype = rsp_ch.best_genotype;
            if (reports_due.size() == 0) begin
                note_mismatch("report arrived with no query outstanding");
            end else begin
                want = reports_due.pop_front();
                if (got.count_zero !== want.count_zero)
                    note_mismatch($sformatf("count_zero got %0d expected %0d",
                                            got.count_zero, want.count_zero));
                if (got.count_one !== want.count_one)
                    note_mismatch($sformatf("count_one got %0d expected %0d",
                                            got.count_one, want.count_one));
                if (got.count_two !== want.count_two)
                    note_mismatch($sformatf("count_two got %0d expected %0d",
                                            got.count_two, want.count_two));
                if (got.dosage_fixed !== want.dosage_fixed)
                    note_mismatch($sformatf("dosage_fixed got %0d expected %0d",
                                            got.dosage_fixed, want.dosage_fixed));
                if (got.quality_fixed !== want.quality_fixed)
                    note_mismatch($sformatf("quality_fixed got %0d expected %0d",
                                            got.quality_fixed, want.quality_fixed));
                if (got.best_genotype !== want.best_genotype)
                    note_mismatch($sformatf("best_genotype got %0d expected %0d",
                                            got.best_genotype, want.best_genotype));
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves anything.
    always @(posedge i_clk) begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Report receiver. It normally takes reports at once, stalls in random bursts
    // while idling is on, and once holds off for a long stretch on request so the
    // block backs up into its request channel.
    initial begin : report_receiver
        int sink_left;
        int sink_rate;
        sink_left = 0;
        sink_rate = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_left == 0) begin
                sink_left = $urandom_range(40, 200);
                sink_rate = $urandom_range(0, 2);
            end
            sink_left--;
            if (sink_hold_request) begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(posedge i_clk);
                sink_hold_request = 1'b0;
            end else if (idling_on && sink_rate != 0 &&
                         $urandom_range(0, 15) < 2 * sink_rate) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 13)) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        request_t rq;
        int pick;
        int steps;
        int slot;
        bit paused;

        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_STORE_DOSAGE;
        cfg_data          <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.kind       <= KIND_ADD;
        req_ch.individual <= '0;
        req_ch.marker     <= '0;
        req_ch.allele_a   <= 1'b0;
        req_ch.allele_b   <= 1'b0;

        // Directed table. Both settings start cleared, so the first add and finish
        // must leave no trace; that shows up in the query after the first real round.
        // Query of a fresh table with no finished round: all zero, class one.
        plan_request(make_request(KIND_QUERY, 8'd0, 10'd0, 1'b0, 1'b0), 1, 1'b1,
                     report_of(0, 0, 0, '0, '0, GENO_ONE));
        plan_request(make_request(KIND_ADD, 8'd255, 10'd1023, 1'b1, 1'b1));
        plan_request(make_request(KIND_FINISH, 8'd0, 10'd0, 1'b0, 1'b0));
        plan_request(make_request(KIND_IGNORED, 8'd255, 10'd1023, 1'b1, 1'b1));
        plan_setting(CFG_STORE_DOSAGE, 1'b1);
        // Three alleles in one round give a sum larger than the round allows.
        plan_request(make_request(KIND_ADD, 8'd255, 10'd1023, 1'b1, 1'b1));
        plan_request(make_request(KIND_ADD, 8'd255, 10'd1023, 1'b1, 1'b0));
        plan_request(make_request(KIND_FINISH, 8'd255, 10'd1023, 1'b1, 1'b1));
        plan_request(make_request(KIND_QUERY, 8'd255, 10'd1023, 1'b0, 1'b0));
        plan_setting(CFG_STORE_DISTRIBUTION, 1'b1);
        // Load one entry with far more double-one pairs than rounds. With a single
        // round the class-two count dominates, the dosage numerator goes negative
        // and clamps to zero, and the quality clamps to one.
        plan_request(make_request(KIND_ADD, 8'd0, 10'd0, 1'b1, 1'b1), OVERLOAD_RUN);
        plan_request(make_request(KIND_QUERY, 8'd0, 10'd0, 1'b0, 1'b0), 1, 1'b1,
                     report_of(0, 0, OVERLOAD_RUN, '0, QUAL_ONE, GENO_TWO));
        // Distribution storage alone still accumulates sums and rounds.
        plan_setting(CFG_STORE_DOSAGE, 1'b0);
        plan_request(make_request(KIND_ADD, 8'd0, 10'd1, 1'b0, 1'b1));
        plan_request(make_request(KIND_ADD, 8'd3, 10'd7, 1'b1, 1'b1));
        plan_request(make_request(KIND_ADD, 8'd3, 10'd7, 1'b0, 1'b1));
        plan_request(make_request(KIND_FINISH, 8'd0, 10'd0, 1'b0, 1'b0));
        // A tie of classes zero and one, then a tie of classes one and two.
        plan_request(make_request(KIND_QUERY, 8'd0, 10'd1, 1'b0, 1'b0));
        plan_request(make_request(KIND_QUERY, 8'd3, 10'd7, 1'b1, 1'b1));
        // Both settings off: the add below is dropped, the entry reads as before.
        plan_setting(CFG_STORE_DISTRIBUTION, 1'b0);
        plan_request(make_request(KIND_ADD, 8'd0, 10'd1, 1'b1, 1'b1));
        plan_request(make_request(KIND_QUERY, 8'd0, 10'd1, 1'b0, 1'b0));
        plan_setting(CFG_STORE_DOSAGE, 1'b1);
        // An untouched entry after two rounds: full dosage and full quality.
        plan_request(make_request(KIND_QUERY, 8'd1, 10'd512, 1'b0, 1'b0), 1, 1'b1,
                     report_of(2, 0, 0, DOSE_MAX, QUAL_ONE, GENO_ZERO));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[i]) begin
            if (directed_plan[i].is_setting)
                write_setting(directed_plan[i].reg_index, directed_plan[i].reg_value);
            else
                repeat (directed_plan[i].reps)
                    offer_request(directed_plan[i].rq, directed_plan[i].pinned,
                                  directed_plan[i].want);
        end

        // A small pool of entries receives most of the traffic so that the counts
        // build up; each entry leans toward one allele pair to spread the classes.
        pool[0] = make_request(KIND_ADD, 8'd255, 10'd1023, 1'b0, 1'b0);
        pool[1] = make_request(KIND_ADD, 8'd0, 10'd1, 1'b0, 1'b0);
        for (int i = 2; i < POOL_SIZE; i++)
            pool[i] = random_request(KIND_ADD);
        for (int i = 0; i < POOL_SIZE; i++)
            pool_bias[i] = 2'($urandom_range(0, 3));

        // Random phases, each with its own settings. The first starts with a long
        // receiver hold-off; the second pauses the sender halfway until every
        // outstanding report is back.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_setting(CFG_STORE_DOSAGE, (phase != 2) ? 1'b1 : 1'b0);
            write_setting(CFG_STORE_DISTRIBUTION,
                          (phase == 1) ? 1'b0 :
                          (phase == 3) ? 1'($urandom_range(0, 1)) : 1'b1);
            if (phase == 0)
                sink_hold_request = 1'b1;
            accepted_items = 0;
            paused = 1'b0;
            while (accepted_items < PHASE_ITEMS) begin
                if (phase == 1 && !paused && accepted_items >= PHASE_ITEMS / 2) begin
                    wait_reports_drained();
                    paused = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    // A sampling round: a few adds on pool entries, some queries in
                    // between, then the finish that closes the round.
                    steps = $urandom_range(1, 6);
                    repeat (steps) begin
                        slot = $urandom_range(0, POOL_SIZE - 1);
                        rq = pool[slot];
                        rq.kind = KIND_ADD;
                        if ($urandom_range(0, 1) == 1)
                            {rq.allele_a, rq.allele_b} = pool_bias[slot];
                        else
                            {rq.allele_a, rq.allele_b} = 2'($urandom_range(0, 3));
                        offer_request(rq, 1'b0, '0);
                        if ($urandom_range(0, 3) == 0) begin
                            rq = pool[$urandom_range(0, POOL_SIZE - 1)];
                            rq.kind = KIND_QUERY;
                            offer_request(rq, 1'b0, '0);
                        end
                    end
                    offer_request(random_request(KIND_FINISH), 1'b0, '0);
                end else if (pick < 85) begin
                    rq = pool[$urandom_range(0, POOL_SIZE - 1)];
                    rq.kind = KIND_QUERY;
                    offer_request(rq, 1'b0, '0);
                end else if (pick < 92) begin
                    offer_request(random_request(KIND_QUERY), 1'b0, '0);
                end else if (pick < 97) begin
                    offer_request(random_request(KIND_ADD), 1'b0, '0);
                end else begin
                    offer_request(random_request(KIND_IGNORED), 1'b0, '0);
                end
            end
        end

        // Closing part, without idling: a run of finishes back to back, then read
        // back the pool and a few other entries.
        write_setting(CFG_STORE_DOSAGE, 1'b1);
        write_setting(CFG_STORE_DISTRIBUTION, 1'b1);
        idling_on = 1'b0;
        repeat (CLOSING_ROUNDS)
            offer_request(random_request(KIND_FINISH), 1'b0, '0);
        for (int i = 0; i < POOL_SIZE; i++) begin
            rq = pool[i];
            rq.kind = KIND_QUERY;
            offer_request(rq, 1'b0, '0);
        end
        offer_request(make_request(KIND_QUERY, 8'd0, 10'd0, 1'b0, 1'b0), 1'b0, '0);
        repeat (8)
            offer_request(random_request(KIND_QUERY), 1'b0, '0);

        wait_reports_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
